// ===== rtl/hgn_pkg.sv =====
// ----------------------------------------------------------------------------
// hgn_pkg
// Shared types and codes for the hop-count gradient neighbor table.
// ----------------------------------------------------------------------------
package hgn_pkg;

  // default sizes
  localparam int MAX_NEIGHBORS_DEF = 16;
  localparam int HOP_BITS_DEF      = 8;

  // packet id multiplier
  localparam logic [32:0] ID_FACTOR = 33'd100000;

  // input item modes
  localparam logic [2:0] MODE_BEACON_RX = 3'd0;
  localparam logic [2:0] MODE_DATA_RX   = 3'd1;
  localparam logic [2:0] MODE_APP_DATA  = 3'd2;
  localparam logic [2:0] MODE_TICK      = 3'd3;
  localparam logic [2:0] MODE_RECV_REQ  = 3'd4;

  // result actions
  localparam logic [2:0] ACT_NONE     = 3'd0;
  localparam logic [2:0] ACT_DELIVER  = 3'd1;
  localparam logic [2:0] ACT_SEND     = 3'd2;
  localparam logic [2:0] ACT_BEACON   = 3'd3;
  localparam logic [2:0] ACT_RECV_REP = 3'd4;

  // configuration register indexes
  localparam logic REG_IS_SINK   = 1'b0;
  localparam logic REG_SELF_ADDR = 1'b1;

  // command broadcast to every table cell
  typedef struct packed {
    logic        upd;     // received frame registers its sender
    logic        beacon;  // frame is a beacon, store its hop count
    logic        hit;     // sender already in some cell
    logic [15:0] addr;    // sender address
  } hgn_cmd_t;

endpackage

// ===== rtl/hgn_cell.sv =====
// ----------------------------------------------------------------------------
// hgn_cell
// One neighbor table slot: address, hop count and valid bit. Slots fill
// from the low end, so a slot takes a new sender when it is empty and its
// lower neighbor is full.
// ----------------------------------------------------------------------------
module hgn_cell #(
  parameter int HOP_BITS = hgn_pkg::HOP_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  hgn_pkg::hgn_cmd_t    cmd,
  input  logic [HOP_BITS-1:0]  hop_wr,
  input  logic [HOP_BITS-1:0]  thr,
  input  logic                 prev_valid,
  output logic                 valid,
  output logic                 match,
  output logic                 recv
);
  import hgn_pkg::*;

  logic [15:0]         addr;
  logic [HOP_BITS-1:0] hop;
  logic                ins;

  // address match and insert point
  assign match = valid && (addr == cmd.addr);
  assign ins   = cmd.upd && !cmd.hit && !valid && prev_valid;

  // receiver test against the own hop count
  assign recv = valid && (hop < thr);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ins) begin
      valid <= 1'b1;
    end
  end

  // slot payload
  always_ff @(posedge clk) begin
    if (ins) begin
      addr <= cmd.addr;
      hop  <= hop_wr;
    end else if (cmd.upd && cmd.beacon && match) begin
      hop <= hop_wr;
    end
  end

endmodule

// ===== rtl/hop_gradient_neighbor_table.sv =====
// ----------------------------------------------------------------------------
// hop_gradient_neighbor_table
// An accepted item is held until the result register is loaded; no new
// item is taken while one is held. The table cells are written in the
// accept cycle and the receiver mask is rebuilt from them at that load.
// A waiting result does not block the next item; a second result waits.
// Reset: table empty, own hop unreachable, mask and sequence counter zero.
// ----------------------------------------------------------------------------
module hop_gradient_neighbor_table #(
  parameter int MAX_NEIGHBORS = hgn_pkg::MAX_NEIGHBORS_DEF,
  parameter int HOP_BITS      = hgn_pkg::HOP_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [15:0] cfg_data,
  // item in
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  mode,
  input  logic [15:0] src_addr,
  input  logic [7:0]  src_hop,
  input  logic [15:0] app_seq,
  // result out
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  action,
  output logic [31:0] packet_id,
  output logic [15:0] seq_out,
  output logic [7:0]  own_hop,
  output logic [15:0] receiver_mask,
  output logic [4:0]  neighbor_count,
  output logic        table_full
);
  import hgn_pkg::*;

  localparam int CW = $clog2(MAX_NEIGHBORS + 1);
  localparam logic [HOP_BITS-1:0] HopUnreach = '1;
  localparam logic [CW-1:0]       CountMax   = CW'(MAX_NEIGHBORS);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_FIN  = 1'b1;

  // configuration and node state
  logic                     is_sink;
  logic [15:0]              self_addr;
  logic [HOP_BITS-1:0]      hop_reg;
  logic [MAX_NEIGHBORS-1:0] recv_mask;
  logic [15:0]              seq_counter;
  logic [CW-1:0]            count;
  logic                     state;

  // item held between accept and result
  logic [2:0]               p_action;
  logic [15:0]              p_seq;
  logic [31:0]              p_prod;
  logic                     p_pid;
  logic                     p_full;
  logic                     p_rebuild;

  // cell chain signals
  hgn_cmd_t                 cmd;
  logic [HOP_BITS-1:0]      hop_in;
  logic [HOP_BITS-1:0]      hop_wr;
  logic [MAX_NEIGHBORS:0]   valid_chain;
  logic [MAX_NEIGHBORS-1:0] match_vec;
  logic [MAX_NEIGHBORS-1:0] recv_vec;

  logic                     accept;
  logic                     is_frame;
  logic                     is_beacon;
  logic                     hit;
  logic [HOP_BITS+7:0]      shop_ext;
  logic [HOP_BITS+7:0]      unreach_ext;
  logic [32:0]              prod;
  logic                     load;

  logic [MAX_NEIGHBORS+15:0] mask_ext;
  logic [CW+4:0]             count_ext;
  logic [HOP_BITS+7:0]       hop_ext;
  logic [MAX_NEIGHBORS-1:0]  mask_now;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign is_beacon = (mode == MODE_BEACON_RX);
  assign is_frame  = is_beacon || (mode == MODE_DATA_RX);
  assign hit       = |match_vec;

  // received hop count, large values mean unreachable
  assign shop_ext    = {{HOP_BITS{1'b0}}, src_hop};
  assign unreach_ext = {8'd0, HopUnreach};
  always_comb begin
    if ((shop_ext >= unreach_ext) || (src_hop == 8'hFF)) begin
      hop_in = HopUnreach;
    end else begin
      hop_in = shop_ext[HOP_BITS-1:0];
    end
  end
  assign hop_wr = is_beacon ? hop_in : HopUnreach;

  // broadcast to the cells
  always_comb begin
    cmd.upd    = accept && is_frame;
    cmd.beacon = accept && is_beacon;
    cmd.hit    = hit;
    cmd.addr   = src_addr;
  end

  // neighbor table: chain of slots
  assign valid_chain[0] = 1'b1;
  for (genvar i = 0; i < MAX_NEIGHBORS; i++) begin : g_cell
    hgn_cell #(
      .HOP_BITS(HOP_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .hop_wr    (hop_wr),
      .thr       (hop_reg),
      .prev_valid(valid_chain[i]),
      .valid     (valid_chain[i+1]),
      .match     (match_vec[i]),
      .recv      (recv_vec[i])
    );
  end

  // packet id product, sum with own address when the result is loaded
  assign prod = {17'd0, app_seq} * ID_FACTOR;

  // accept and control
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      is_sink     <= 1'b0;
      self_addr   <= 16'd0;
      hop_reg     <= HopUnreach;
      recv_mask   <= '0;
      seq_counter <= 16'd0;
      count       <= '0;
    end else begin
      if (accept) begin
        state <= ST_FIN;
        if (is_frame && !hit && (count != CountMax)) begin
          count <= count + 1'b1;
        end
        if (is_beacon && (hop_in < hop_reg)) begin
          hop_reg <= hop_in + 1'b1;
        end
        if ((mode == MODE_TICK) || ((mode == MODE_DATA_RX) && !is_sink)) begin
          seq_counter <= seq_counter + 16'd1;
        end
      end else if (load) begin
        state <= ST_IDLE;
        if (p_rebuild) begin
          recv_mask <= recv_vec;
        end
      end
      if (cfg_we) begin
        case (cfg_idx)
          REG_IS_SINK: begin
            is_sink <= cfg_data[0];
            hop_reg <= cfg_data[0] ? '0 : HopUnreach;
          end
          REG_SELF_ADDR: self_addr <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // item details held for the result
  always_ff @(posedge clk) begin
    if (accept) begin
      p_seq     <= 16'd0;
      p_pid     <= 1'b0;
      p_full    <= is_frame && !hit && (count == CountMax);
      p_rebuild <= is_beacon && (hop_in < hop_reg);
      p_prod    <= prod[31:0];
      case (mode)
        MODE_BEACON_RX: p_action <= ACT_NONE;
        MODE_DATA_RX: begin
          if (is_sink) begin
            p_action <= ACT_DELIVER;
          end else begin
            p_action <= ACT_SEND;
            p_seq    <= seq_counter;
          end
        end
        MODE_APP_DATA: begin
          if (!is_sink && (recv_mask != '0)) begin
            p_action <= ACT_SEND;
            p_pid    <= 1'b1;
          end else begin
            p_action <= ACT_NONE;
          end
        end
        MODE_TICK: begin
          p_action <= ACT_BEACON;
          p_seq    <= seq_counter;
        end
        MODE_RECV_REQ: p_action <= ACT_RECV_REP;
        default: p_action <= ACT_NONE;
      endcase
    end
  end

  // result forming
  assign load      = (state == ST_FIN) && (!out_valid || out_ready);
  assign mask_now  = p_rebuild ? recv_vec : recv_mask;
  assign mask_ext  = {16'd0, mask_now};
  assign count_ext = {5'd0, count};
  assign hop_ext   = {8'd0, hop_reg};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (load) begin
      action         <= p_action;
      packet_id      <= p_pid ? (p_prod + {16'd0, self_addr}) : 32'd0;
      seq_out        <= p_seq;
      own_hop        <= (hop_ext > {{HOP_BITS{1'b0}}, 8'hFF}) ? 8'hFF : hop_ext[7:0];
      receiver_mask  <= mask_ext[15:0];
      neighbor_count <= count_ext[4:0];
      table_full     <= p_full;
    end
  end

endmodule
